// ===== src/rau_pkg.sv =====
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
  localparam int DW = 32;
  localparam int MW = 2 * DW;
  localparam int NW = MW + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZDEN = 2'd1, ST_DIVZ = 2'd2, ST_OVF = 2'd3
  } status_t;

  typedef struct packed {
    op_t            op;
    logic           err;
    status_t        status;
    logic           an_neg;
    logic [DW-1:0]  an_mag;
    logic           ad_neg;
    logic [DW-1:0]  ad_mag;
    logic           bn_neg;
    logic [DW-1:0]  bn_mag;
    logic           bd_neg;
    logic [DW-1:0]  bd_mag;
  } job_t;

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    mag_of = v[DW-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

// ===== src/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level, front checker, job queue and gcd back end
// depends on rau_pkg, rau_front, rau_back
//
// in channel: one beat carries the operation and two fractions; out channel:
// one beat per input with reduced numerator, denominator and status.
// operand errors (zero denominator, division by zero) give 0/0 at once.
// a zero result skips the gcd and divisions and comes out as 0/1.
// otherwise the back end runs three multiplies on one shared 32x32 unit,
// a binary gcd and two 64-step restoring divisions through one shift-subtract
// unit, and takes a new job only when it is idle.
// a two-entry queue sits between front and back, so up to two further
// beats are taken while the back end works or waits.
// the result is held in an output register until out_tready; the back end
// stalls meanwhile and the queue fills, then in_tready drops.
// reset empties the queue and returns the back end to idle.
module rational_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // req_type, a_num, a_den, b_num, b_den, pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // res_num, res_den, status, pad
);
  import rau_pkg::*;

  logic jv, jr;
  job_t jb;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .job_valid(jv), .job_ready(jr), .job(jb)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(jb),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule

// ===== src/rau_front.sv =====
// rau_front: accepts input beats, checks operand errors, splits sign and magnitude
// depends on rau_pkg
module rau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [135:0]       in_tdata,
  output logic               job_valid,
  input  logic               job_ready,
  output rau_pkg::job_t      job
);
  import rau_pkg::*;

  logic [DW-1:0] an, ad, bn, bd;
  op_t op;
  job_t j;

  assign op = op_t'(in_tdata[1:0]);
  assign an = in_tdata[2 +: DW];
  assign ad = in_tdata[2+DW +: DW];
  assign bn = in_tdata[2+2*DW +: DW];
  assign bd = in_tdata[2+3*DW +: DW];

  always_comb begin
    j.op = op;
    j.an_neg = an[DW-1]; j.an_mag = mag_of(an);
    j.ad_neg = ad[DW-1]; j.ad_mag = mag_of(ad);
    j.bn_neg = bn[DW-1]; j.bn_mag = mag_of(bn);
    j.bd_neg = bd[DW-1]; j.bd_mag = mag_of(bd);
    j.err = 1'b1;
    priority if (ad == '0 || bd == '0) begin
      j.status = ST_ZDEN;
    end else if (op == OP_DIV && bn == '0) begin
      j.status = ST_DIVZ;
    end else begin
      j.status = ST_OK;
      j.err = 1'b0;
    end
  end

  // two-entry queue
  job_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r;
  logic push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign pop = job_valid && job_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (pop) rd_r <= ~rd_r;
    end
    if (push) q_r[rd_r ^ cnt_r[0]] <= j;
  end
endmodule

// ===== src/rau_back.sv =====
// rau_back: cross products, binary gcd and exact divisions for one job at a time
// depends on rau_pkg
module rau_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  rau_pkg::job_t      job,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_ADD, S_GCD0, S_GCD, S_DIVN, S_DIVD, S_DONE, S_OUT
  } state_t;

  state_t st_r;
  job_t j_r;
  logic [MW-1:0] p1_r, p2_r, den_r, u_r, v_r, g_r;
  logic n1neg_r, n2neg_r, negnum_r, neg_r;
  logic [6:0] k_r, cnt_r;
  logic [MW-1:0] dvd_r;
  logic [DW-1:0] rnum_r;
  logic [DW-2:0] rden_r;
  status_t stat_r;

  logic [DW-1:0] ma, mb;
  logic [MW-1:0] prod;
  assign prod = ma * mb;

  always_comb begin
    ma = j_r.an_mag; mb = j_r.bd_mag;
    unique case (st_r)
      S_M1: begin
        ma = j_r.an_mag;
        mb = (j_r.op == OP_MUL) ? j_r.bn_mag : j_r.bd_mag;
      end
      S_M2: begin
        ma = (j_r.op == OP_DIV) ? j_r.bn_mag : j_r.bn_mag;
        mb = j_r.ad_mag;
      end
      S_ADD: begin
        ma = j_r.ad_mag;
        mb = (j_r.op == OP_DIV) ? j_r.bn_mag : j_r.bd_mag;
      end
      default: begin
        ma = j_r.an_mag; mb = j_r.bd_mag;
      end
    endcase
  end

  // signed magnitude sum of p1 and p2
  logic [NW-1:0] ssum;
  logic sneg;
  always_comb begin
    if (n1neg_r == n2neg_r) begin
      ssum = {1'b0, p1_r} + {1'b0, p2_r}; sneg = n1neg_r;
    end else if (p1_r >= p2_r) begin
      ssum = {1'b0, p1_r - p2_r}; sneg = n1neg_r;
    end else begin
      ssum = {1'b0, p2_r - p1_r}; sneg = n2neg_r;
    end
  end

  logic [NW-1:0] numw_r;
  logic [NW:0] trial;
  logic [NW-1:0] dv;
  assign dv = {1'b0, g_r};
  logic [NW-1:0] rem_w_r;
  assign trial = {rem_w_r, dvd_r[MW-1]} - {1'b0, dv};

  logic [NW-1:0] nmag;
  logic ovf;
  always_comb begin
    nmag = numw_r;
    ovf = (den_r > {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}}) ||
          (neg_r ? (nmag > {{(NW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}})
                 : (nmag > {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}}));
  end

  logic [NW-1:0] nsig;
  assign nsig = neg_r ? (~numw_r + 1'b1) : numw_r;

  assign job_ready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {7'd0, stat_r, rden_r, rnum_r};

  logic [MW-1:0] ucur, vcur;
  assign ucur = u_r;
  assign vcur = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          j_r <= job;
          if (job.err) begin
            rnum_r <= '0; rden_r <= '0; stat_r <= job.status; st_r <= S_OUT;
          end else begin
            st_r <= S_M1;
          end
        end
        S_M1: begin
          p1_r <= prod;
          n1neg_r <= j_r.an_neg ^ ((j_r.op == OP_MUL) ? j_r.bn_neg : j_r.bd_neg);
          st_r <= S_M2;
        end
        S_M2: begin
          p2_r <= prod;
          n2neg_r <= j_r.bn_neg ^ j_r.ad_neg ^ (j_r.op == OP_SUB);
          st_r <= S_ADD;
        end
        S_ADD: begin
          den_r <= prod;
          neg_r <= 1'b0;
          if (j_r.op == OP_ADD || j_r.op == OP_SUB) begin
            numw_r <= ssum; negnum_r <= sneg;
          end else begin
            numw_r <= {1'b0, p1_r}; negnum_r <= n1neg_r;
          end
          n2neg_r <= j_r.ad_neg ^ ((j_r.op == OP_DIV) ? j_r.bn_neg : j_r.bd_neg);
          st_r <= S_GCD0;
        end
        S_GCD0: begin
          if (numw_r == '0) begin
            rnum_r <= '0; rden_r <= {{(DW-2){1'b0}}, 1'b1}; stat_r <= ST_OK;
            st_r <= S_OUT;
          end else begin
            u_r <= numw_r[MW-1:0];
            v_r <= den_r;
            k_r <= '0;
            neg_r <= negnum_r ^ n2neg_r;
            st_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (ucur == vcur) begin
            g_r <= ucur << k_r[5:0];
            dvd_r <= numw_r[MW-1:0];
            rem_w_r <= '0; cnt_r <= '0;
            st_r <= S_DIVN;
          end else if (!ucur[0] && !vcur[0]) begin
            u_r <= ucur >> 1; v_r <= vcur >> 1; k_r <= k_r + 7'd1;
          end else if (!ucur[0]) begin
            u_r <= ucur >> 1;
          end else if (!vcur[0]) begin
            v_r <= vcur >> 1;
          end else if (ucur > vcur) begin
            u_r <= (ucur - vcur) >> 1;
          end else begin
            v_r <= (vcur - ucur) >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          if (cnt_r == 7'(MW-1)) begin
            cnt_r <= '0; rem_w_r <= '0;
            if (st_r == S_DIVN) begin
              numw_r <= {1'b0, dvd_r[MW-2:0], ~trial[NW]};
              dvd_r <= den_r;
              st_r <= S_DIVD;
            end else begin
              den_r <= {dvd_r[MW-2:0], ~trial[NW]};
              st_r <= S_DONE;
            end
          end else begin
            dvd_r <= {dvd_r[MW-2:0], ~trial[NW]};
            if (trial[NW]) rem_w_r <= {rem_w_r[NW-2:0], dvd_r[MW-1]};
            else rem_w_r <= trial[NW-1:0];
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_DONE: begin
          rnum_r <= nsig[DW-1:0];
          rden_r <= den_r[DW-2:0];
          stat_r <= ovf ? ST_OVF : ST_OK;
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
